// ----- sv/esmv_pkg.sv -----
// Shared types and constants for the ELLPACK sparse matrix-vector product block.
// No dependencies; every other file but esmv_ram.sv imports this package.
package esmv_pkg;

	localparam int VECTOR_DEPTH_DEF = 4096;
	localparam int COLUMN_COUNT_W   = 13;
	localparam int ROW_COUNT_W      = 16;
	localparam int CFG_DATA_W       = 16;
	localparam int CFG_INDEX_W      = 1;
	localparam int RESULT_FIFO_DEPTH = 8;
	localparam int RESULT_PTR_W     = $clog2(RESULT_FIFO_DEPTH);

	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 1'd1;

	localparam logic OP_VECTOR_WRITE = 1'b0;
	localparam logic OP_MATRIX_ENTRY = 1'b1;

	localparam logic [COLUMN_COUNT_W-1:0] COLUMN_COUNT_RESET = 13'd4096;
	localparam logic [ROW_COUNT_W-1:0]    ROW_COUNT_RESET    = 16'd65535;

	typedef struct packed {
		logic               op;
		logic [11:0]        index;
		logic signed [31:0] value;
		logic               last_in_row;
	} item_t;

	typedef struct packed {
		logic [15:0]        row_index;
		logic signed [31:0] row_sum;
		logic               saturated;
	} result_t;

endpackage

// ----- sv/esmv_if.sv -----
// Valid/ready stream interfaces for input items and row results.
// Depends on esmv_pkg for the payload types.
interface esmv_item_if import esmv_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface esmv_result_if import esmv_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/esmv_ram.sv -----
// Generic simple dual-port synchronous RAM with one write and one registered read port.
// No dependencies.
module esmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- sv/ell_sparse_matrix_vector_product.sv -----
// Top level of the ELLPACK sparse matrix-vector product block.
// Depends on esmv_pkg, the stream interfaces in esmv_if.sv and esmv_ram.

// The block takes one transaction per clock cycle while input is not held off: vector writes go
// straight into the vector store, and matrix entries read the store, multiply in the next stage
// and accumulate in the one after; a row result is registered in s3, written to the result queue
// and then shown on the result channel. Results wait in an eight-entry queue; input is held off
// only when the queued results plus the row-closing entries still in the pipeline reach eight.
module ell_sparse_matrix_vector_product import esmv_pkg::*; #(
	parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	esmv_item_if.sink              items,
	esmv_result_if.source          results
);

	localparam int ADDR_W = $clog2(VECTOR_DEPTH);

	logic [COLUMN_COUNT_W-1:0] column_count_q;
	logic [ROW_COUNT_W-1:0]    row_count_q;

	logic              accept;
	logic              in_store;
	logic              entry_ok;
	logic [ADDR_W-1:0] addr;
	logic [31:0]       rd_data;

	logic               s1_valid;
	logic               s1_op;
	logic               s1_ok;
	logic               s1_last;
	logic signed [31:0] s1_value;

	logic               s2_valid;
	logic               s2_op;
	logic               s2_ok;
	logic               s2_last;
	logic signed [63:0] s2_prod;

	logic signed [63:0] acc_q;
	logic               ovf_q;
	logic [15:0]        row_counter_q;
	logic signed [63:0] acc_sum;
	logic               add_ovf;
	logic signed [63:0] acc_next;

	logic               s3_valid;
	logic signed [63:0] s3_acc;
	logic               s3_ovf;
	logic [15:0]        s3_row;

	logic signed [48:0] rounded;
	logic               conv_sat;
	result_t            conv_result;

	result_t                 fifo_q [RESULT_FIFO_DEPTH];
	logic [RESULT_PTR_W-1:0] wr_ptr_q;
	logic [RESULT_PTR_W-1:0] rd_ptr_q;
	logic [RESULT_PTR_W:0]   count_q;
	logic [RESULT_PTR_W:0]   pending;
	logic                    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLUMN_COUNT_RESET;
			row_count_q    <= ROW_COUNT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_COLUMN_COUNT: column_count_q <= wr_data[COLUMN_COUNT_W-1:0];
				CFG_ROW_COUNT:    row_count_q    <= wr_data[ROW_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign pending = (RESULT_PTR_W+1)'(s1_valid & s1_last) + (RESULT_PTR_W+1)'(s2_valid & s2_last)
		+ (RESULT_PTR_W+1)'(s3_valid);
	assign items.ready = (count_q + pending) < (RESULT_PTR_W+1)'(RESULT_FIFO_DEPTH);
	assign accept = items.valid & items.ready;

	assign in_store = 17'(items.payload.index) < 17'(VECTOR_DEPTH);
	assign entry_ok = in_store && (items.payload.value != 32'sd0)
		&& ({1'b0, items.payload.index} < column_count_q);
	assign addr = ADDR_W'(items.payload.index);

	esmv_ram #(
		.WIDTH(32),
		.DEPTH(VECTOR_DEPTH)
	) u_vector_store (
		.clk     (clk),
		.wr_en   (accept && items.payload.op == OP_VECTOR_WRITE && in_store),
		.wr_addr (addr),
		.wr_data (items.payload.value),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		s1_op    <= items.payload.op;
		s1_ok    <= entry_ok;
		s1_last  <= items.payload.last_in_row;
		s1_value <= items.payload.value;
		s2_op    <= s1_op;
		s2_ok    <= s1_ok;
		s2_last  <= s1_last;
		s2_prod  <= s1_value * $signed(rd_data);
	end

	always_comb begin
		acc_sum = acc_q + s2_prod;
		add_ovf = s2_ok && (acc_q[63] == s2_prod[63]) && (acc_sum[63] != acc_q[63]);
		if (!s2_ok) begin
			acc_next = acc_q;
		end else if (add_ovf) begin
			acc_next = acc_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			acc_next = acc_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			ovf_q         <= 1'b0;
			row_counter_q <= '0;
			s3_valid      <= 1'b0;
		end else begin
			s3_valid <= 1'b0;
			if (s2_valid) begin
				if (s2_op == OP_VECTOR_WRITE) begin
					acc_q         <= '0;
					ovf_q         <= 1'b0;
					row_counter_q <= '0;
				end else if (s2_last) begin
					s3_valid      <= row_counter_q < row_count_q;
					acc_q         <= '0;
					ovf_q         <= 1'b0;
					row_counter_q <= row_counter_q + 16'd1;
				end else begin
					acc_q <= acc_next;
					ovf_q <= ovf_q | add_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		s3_acc <= acc_next;
		s3_ovf <= ovf_q | add_ovf;
		s3_row <= row_counter_q;
	end

	always_comb begin
		rounded  = 49'(signed'(s3_acc[63:16])) + 49'({48'd0, s3_acc[15]});
		conv_sat = rounded[48:31] != {18{rounded[48]}};
		conv_result.row_index = s3_row;
		conv_result.saturated = s3_ovf | conv_sat;
		if (conv_sat) begin
			conv_result.row_sum = rounded[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			conv_result.row_sum = rounded[31:0];
		end
	end

	assign pop = results.valid & results.ready;
	assign results.valid = count_q != '0;
	assign results.payload = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (s3_valid) begin
				wr_ptr_q <= wr_ptr_q + RESULT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RESULT_PTR_W'(1);
			end
			count_q <= count_q + (RESULT_PTR_W+1)'(s3_valid) - (RESULT_PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s3_valid) begin
			fifo_q[wr_ptr_q] <= conv_result;
		end
	end

endmodule

// ----- bench/ell_sparse_matrix_vector_product_tb.sv -----
// Self-checking testbench for the ELLPACK sparse matrix-vector product block.
// Uses esmv_pkg, the stream interfaces of esmv_if.sv and the top level under test.
module ell_sparse_matrix_vector_product_tb;
	import esmv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DIRECTED_N    = 23;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} directed_row_t;

	localparam result_t NO_ROW = '0;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	esmv_item_if   items_ch ();
	esmv_result_if results_ch ();

	ell_sparse_matrix_vector_product uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.items    (items_ch),
		.results  (results_ch)
	);

	// Local copy of the block state used to predict row sums.
	logic signed [31:0]        vec_copy [VECTOR_DEPTH_DEF];
	bit                        vec_written [VECTOR_DEPTH_DEF];
	int                        written_pos [$];
	logic [63:0]               acc_q32;
	logic [15:0]               row_ctr;
	bit                        ovf_seen;
	logic [COLUMN_COUNT_W-1:0] cfg_columns;
	logic [ROW_COUNT_W-1:0]    cfg_rows;

	result_t pending_rows [$];
	int      errors;
	int      items_sent;
	int      tx_idle_pct;
	int      rx_idle_pct;
	int      hold_off_cycles;
	int      cycle_count;

	directed_row_t directed_rows [DIRECTED_N] = '{
		'{'{OP_VECTOR_WRITE, 12'd0,    32'h0001_0000, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_VECTOR_WRITE, 12'd4095, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_VECTOR_WRITE, 12'd1,    32'h8000_0000, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_VECTOR_WRITE, 12'd2,    32'hFFFF_0000, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd0,    32'h0002_0000, 1'b1}, 1'b1,
			'{16'd0, 32'h0002_0000, 1'b0}},
		'{'{OP_MATRIX_ENTRY, 12'd4095, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd4095, 32'h7FFF_FFFF, 1'b1}, 1'b1,
			'{16'd1, 32'h7FFF_FFFF, 1'b1}},
		'{'{OP_MATRIX_ENTRY, 12'd1,    32'h8000_0000, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd1,    32'h8000_0000, 1'b1}, 1'b1,
			'{16'd2, 32'h7FFF_FFFF, 1'b1}},
		'{'{OP_MATRIX_ENTRY, 12'd1,    32'h7FFF_FFFF, 1'b1}, 1'b1,
			'{16'd3, 32'h8000_0000, 1'b1}},
		'{'{OP_MATRIX_ENTRY, 12'd0,    32'h0000_0000, 1'b1}, 1'b1,
			'{16'd4, 32'h0000_0000, 1'b0}},
		'{'{OP_VECTOR_WRITE, 12'd3,    32'h0000_8000, 1'b1}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd3,    32'h0000_0001, 1'b1}, 1'b1,
			'{16'd0, 32'h0000_0001, 1'b0}},
		'{'{OP_MATRIX_ENTRY, 12'd0,    32'h0001_0000, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_VECTOR_WRITE, 12'd5,    32'hFFFF_8000, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd5,    32'h0000_0001, 1'b1}, 1'b1,
			'{16'd0, 32'h0000_0000, 1'b0}},
		'{'{OP_MATRIX_ENTRY, 12'd2,    32'h8000_0000, 1'b1}, 1'b1,
			'{16'd1, 32'h7FFF_FFFF, 1'b1}},
		'{'{OP_MATRIX_ENTRY, 12'd0,    32'h8000_0000, 1'b1}, 1'b1,
			'{16'd2, 32'h8000_0000, 1'b0}},
		'{'{OP_MATRIX_ENTRY, 12'd1,    32'h7FFF_FFFF, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd1,    32'h7FFF_FFFF, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd1,    32'h7FFF_FFFF, 1'b1}, 1'b1,
			'{16'd3, 32'h8000_0000, 1'b1}},
		'{'{OP_MATRIX_ENTRY, 12'd4095, 32'h0000_0001, 1'b0}, 1'b0, NO_ROW},
		'{'{OP_MATRIX_ENTRY, 12'd4095, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_ROW}
	};

	function automatic bit dot_step(input item_t it, output result_t row);
		longint      prod;
		logic [63:0] sum;
		logic [63:0] q;
		bit          sat;
		bit          emitted;
		row = '0;
		emitted = 1'b0;
		if (it.op == OP_VECTOR_WRITE) begin
			vec_copy[it.index] = it.value;
			if (!vec_written[it.index]) begin
				vec_written[it.index] = 1'b1;
				written_pos.push_back(int'(it.index));
			end
			row_ctr = '0;
			acc_q32 = '0;
			ovf_seen = 1'b0;
			return 1'b0;
		end
		if (it.value != 0 && {1'b0, it.index} < cfg_columns) begin
			prod = longint'(it.value) * longint'(vec_copy[it.index]);
			sum = acc_q32 + prod;
			if (acc_q32[63] == prod[63] && sum[63] != acc_q32[63]) begin
				sum = acc_q32[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
				ovf_seen = 1'b1;
			end
			acc_q32 = sum;
		end
		if (it.last_in_row) begin
			if (row_ctr < cfg_rows) begin
				q = $signed(acc_q32) >>> 16;
				q = q + acc_q32[15];
				sat = ovf_seen;
				if (q[63:31] != {33{q[31]}}) begin
					sat = 1'b1;
					row.row_sum = q[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end else begin
					row.row_sum = q[31:0];
				end
				row.row_index = row_ctr;
				row.saturated = sat;
				emitted = 1'b1;
			end
			acc_q32 = '0;
			ovf_seen = 1'b0;
			row_ctr = row_ctr + 16'd1;
		end
		return emitted;
	endfunction

	function automatic logic [31:0] rand_q16();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h0000_0001;
				endcase
			end
			2: v = '0;
			default: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
		return v;
	endfunction

	function automatic logic [11:0] pick_vector_pos();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0;
			1, 2, 3, 4: return 12'($urandom_range(0, 4095));
			default: return 12'($urandom_range(0, int'(cfg_columns) - 1));
		endcase
	endfunction

	// Columns always come from written store entries, apart from columns beyond the
	// configured count, which are skipped.
	function automatic logic [11:0] pick_column(input bit want_valid);
		int c;
		if (!want_valid && cfg_columns < 13'd4096 && $urandom_range(0, 1) != 0)
			return 12'($urandom_range(int'(cfg_columns), 4095));
		c = written_pos[$urandom_range(0, written_pos.size() - 1)];
		for (int t = 0; t < 16 && want_valid && c >= int'(cfg_columns); t++)
			c = written_pos[$urandom_range(0, written_pos.size() - 1)];
		return 12'(c);
	endfunction

	task automatic send_item(input item_t it, input bit typed, input result_t typed_row);
		result_t row;
		bit      has_row;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.payload <= it;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		has_row = dot_step(it, row);
		if (typed)
			pending_rows.push_back(typed_row);
		else if (has_row)
			pending_rows.push_back(row);
		items_sent++;
	endtask

	task automatic settle();
		items_ch.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		if (idx == CFG_COLUMN_COUNT)
			cfg_columns = data[COLUMN_COUNT_W-1:0];
		else
			cfg_rows = data[ROW_COUNT_W-1:0];
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// One to five vector writes followed by one to eight rows of one to four entries; now and then
	// the last row is left open so that the next vector write discards it.
	task automatic gen_problem();
		item_t it;
		int    n_writes;
		int    n_rows;
		int    n_entries;
		bit    broken;
		n_writes = $urandom_range(1, 5);
		n_rows = $urandom_range(1, 8);
		broken = ($urandom_range(0, 9) == 0);
		for (int w = 0; w < n_writes; w++) begin
			it.op = OP_VECTOR_WRITE;
			it.index = pick_vector_pos();
			it.value = rand_q16();
			it.last_in_row = ($urandom_range(0, 3) == 0);
			send_item(it, 1'b0, NO_ROW);
		end
		for (int r = 0; r < n_rows; r++) begin
			n_entries = $urandom_range(1, 4);
			for (int e = 0; e < n_entries; e++) begin
				it.op = OP_MATRIX_ENTRY;
				it.index = pick_column($urandom_range(0, 4) != 0);
				it.value = rand_q16();
				it.last_in_row = (e == n_entries - 1) && !(broken && r == n_rows - 1);
				send_item(it, 1'b0, NO_ROW);
			end
		end
	endtask

	task automatic run_phase(input int columns, input int rows, input int n_items, input int hold);
		int start;
		settle();
		write_reg(CFG_COLUMN_COUNT, 16'(columns));
		write_reg(CFG_ROW_COUNT, 16'(rows));
		hold_off_cycles = hold;
		start = items_sent;
		while (items_sent - start < n_items)
			gen_problem();
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d rows outstanding", $time, pending_rows.size());
			$display("ell_sparse_matrix_vector_product: mismatch");
			$finish;
		end
	end

	initial begin
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles = hold_off_cycles - 1;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected row transaction, expected none, got %p",
					$time, results_ch.payload);
				errors++;
			end else begin
				want = pending_rows.pop_front();
				if (results_ch.payload.row_index !== want.row_index) begin
					$display("%0t: row_index expected %0d got %0d", $time,
						want.row_index, results_ch.payload.row_index);
					errors++;
				end
				if (results_ch.payload.row_sum !== want.row_sum) begin
					$display("%0t: row_sum of row %0d expected %h got %h", $time,
						want.row_index, want.row_sum, results_ch.payload.row_sum);
					errors++;
				end
				if (results_ch.payload.saturated !== want.saturated) begin
					$display("%0t: saturated of row %0d expected %b got %b", $time,
						want.row_index, want.saturated, results_ch.payload.saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		cycle_count = 0;
		hold_off_cycles = 0;
		tx_idle_pct = 30;
		rx_idle_pct = 46;
		acc_q32 = '0;
		row_ctr = '0;
		ovf_seen = 1'b0;
		cfg_columns = COLUMN_COUNT_RESET;
		cfg_rows = ROW_COUNT_RESET;
		foreach (vec_written[i])
			vec_written[i] = 1'b0;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		items_ch.valid <= 1'b0;
		items_ch.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

		run_phase(4096, 65535, 150, 0);
		run_phase(1, 1, 100, 0);

		tx_idle_pct = 46;
		rx_idle_pct = 30;
		run_phase($urandom_range(2, 4095), $urandom_range(2, 16), 120, 0);
		run_phase($urandom_range(1, 64), 3, 100, 0);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase($urandom_range(1, 4096), 65535, 130, 300);

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("ell_sparse_matrix_vector_product: match");
		end else begin
			$display("ell_sparse_matrix_vector_product: mismatch");
		end
		$finish;
	end

endmodule
